// File: hw/rtl/sig_pkg.sv
// ----------------------------------------------------------------------------
// sig_pkg: shared types and constants of the slice index generator
// Request and result word layouts, result status codes, sequence bounds and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sig_pkg;

    // longest sequence handled, longer lengths saturate to it
    localparam logic [6:0] MAX_LEN = 7'd64;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // request word
    typedef struct packed {
        logic [6:0]         seq_length;
        logic               has_start;
        logic signed [15:0] start_pos;
        logic               has_stop;
        logic signed [15:0] stop_pos;
        logic               has_stride;
        logic signed [15:0] stride;
    } t_sig_in;

    // result word
    typedef struct packed {
        logic [5:0] elem_index;
        logic [1:0] status;
        logic       last;
    } t_sig_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic norm;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

// File: hw/rtl/sig_ctrl.sv
// ----------------------------------------------------------------------------
// sig_ctrl: slice index generator sequencer
// Walks each request through capture, bound normalization and index
// emission, one result word per cycle until the datapath flags the last one.
// ----------------------------------------------------------------------------
module sig_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sig_pkg::t_dp_status i_dp_status,
    output sig_pkg::t_dp_cmd  o_dp_cmd,
    output logic              o_busy
);
    import sig_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NORM = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_NORM;
            end
            S_NORM: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_dp_status.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath commands
    always_comb begin
        o_dp_cmd.load = (r_state == S_IDLE) && i_start;
        o_dp_cmd.norm = (r_state == S_NORM);
        o_dp_cmd.emit = (r_state == S_EMIT);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hw/rtl/sig_dp.sv
// ----------------------------------------------------------------------------
// sig_dp: slice index generator datapath
// Holds the request word, normalizes start and stop against the sequence
// length and step sign, then steps the index register once per emitted word.
// ----------------------------------------------------------------------------
module sig_dp (
    input  logic                i_clk,
    input  sig_pkg::t_sig_in    i_in,
    input  sig_pkg::t_dp_cmd    i_dp_cmd,
    output sig_pkg::t_dp_status o_dp_status,
    output sig_pkg::t_sig_out   o_out
);
    import sig_pkg::*;

    // negative bounds count from the end, then clamp into [lo, hi]
    function automatic logic signed [17:0] adjust_bound(
        input logic signed [17:0] v,
        input logic signed [17:0] len,
        input logic signed [17:0] lo,
        input logic signed [17:0] hi
    );
        logic signed [17:0] r;
        r = v;
        if (v < 0) begin
            r = v + len;
            if (r < lo) r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    t_sig_in            r_in;
    logic signed [7:0]  r_idx;
    logic signed [7:0]  r_stop;
    logic signed [15:0] r_step;
    logic               r_pos;
    logic [1:0]         r_status;

    logic [6:0]         len_sat;
    logic signed [17:0] len_s;
    logic signed [17:0] step_s;
    logic               step_zero;
    logic               pos;
    logic signed [17:0] lo_s;
    logic signed [17:0] hi_s;
    logic signed [17:0] start_a;
    logic signed [17:0] stop_a;
    logic               nonempty;
    logic signed [17:0] next_idx;
    logic signed [17:0] stop_ext;
    logic               more;

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) r_in <= i_in;
    end

    // bound normalization
    always_comb begin
        len_sat   = (r_in.seq_length > MAX_LEN) ? MAX_LEN : r_in.seq_length;
        len_s     = $signed({11'd0, len_sat});
        step_zero = r_in.has_stride && (r_in.stride == 16'sd0);
        step_s    = r_in.has_stride ? $signed({{2{r_in.stride[15]}}, r_in.stride}) : 18'sd1;
        pos       = !step_s[17];
        lo_s      = pos ? 18'sd0 : -18'sd1;
        hi_s      = pos ? len_s : len_s - 18'sd1;
        if (r_in.has_start) begin
            start_a = adjust_bound($signed({{2{r_in.start_pos[15]}}, r_in.start_pos}),
                                   len_s, lo_s, hi_s);
        end else begin
            start_a = pos ? lo_s : hi_s;
        end
        if (r_in.has_stop) begin
            stop_a = adjust_bound($signed({{2{r_in.stop_pos[15]}}, r_in.stop_pos}),
                                  len_s, lo_s, hi_s);
        end else begin
            stop_a = pos ? hi_s : lo_s;
        end
        nonempty = pos ? (start_a < stop_a) : (start_a > stop_a);
    end

    // index stepping and end test
    always_comb begin
        next_idx = $signed({{10{r_idx[7]}}, r_idx}) + $signed({{2{r_step[15]}}, r_step});
        stop_ext = $signed({{10{r_stop[7]}}, r_stop});
        more     = r_pos ? (next_idx < stop_ext) : (next_idx > stop_ext);
    end

    // normalized bounds and walking index
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.norm) begin
            r_idx  <= start_a[7:0];
            r_stop <= stop_a[7:0];
            r_step <= step_s[15:0];
            r_pos  <= pos;
            if (step_zero) begin
                r_status <= ST_ERROR;
            end else if (!nonempty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_dp_cmd.emit && more) begin
            r_idx <= next_idx[7:0];
        end
    end

    // result word
    always_comb begin
        o_dp_status.last = (r_status != ST_OK) || !more;
        o_out.elem_index = (r_status == ST_OK) ? r_idx[5:0] : 6'd0;
        o_out.status     = r_status;
        o_out.last       = o_dp_status.last;
    end

endmodule

// File: hw/rtl/slice_index_generator_top.sv
// ----------------------------------------------------------------------------
// slice_index_generator_top: slice bound normalizer and index walker
// Normalizes start, stop and step of a slice over a sequence and emits the
// selected element indices in order, the last one flagged.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. It is
// captured in S_IDLE and its bounds are normalized in S_NORM, then one result
// word comes out per cycle on o_out with o_valid high for that cycle only;
// the receiver cannot stall it. A request selects at most 64 indices of a
// 64-element sequence; an empty selection or a zero step gives one status
// word. The single index adder is stepped once per emitted word. o_busy
// falls in the cycle after the last word, when the next request may be
// taken.
module slice_index_generator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sig_pkg::t_sig_in  i_in,
    output logic              o_busy,
    output logic              o_valid,
    output sig_pkg::t_sig_out o_out
);
    import sig_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    sig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd),
        .o_busy      (o_busy)
    );

    // bound normalization and index walk
    sig_dp u_dp (
        .i_clk       (i_clk),
        .i_in        (i_in),
        .i_dp_cmd    (dp_cmd),
        .o_dp_status (dp_status),
        .o_out       (o_out)
    );

    assign o_valid = dp_cmd.emit;

    // a word only comes out while a request is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result word outside a request");

    // status words end the request at once
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status != ST_OK)) |-> o_out.last)
        else $error("status word without last");

    // the last word closes the burst
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |=> (!o_valid && !o_busy))
        else $error("words after last");

    // index words run back to back until last
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.last) |=> o_valid)
        else $error("gap inside index burst");

    // a taken request yields its first word once the normalization state has passed
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("first word missing");

endmodule
